FILE: rtl/pihh_pkg.sv
// ----------------------------------------------------------------------------
// pihh_pkg: shared types and constants of the hexahedron point test
// Widths, sequencer codes, the face triangle table and the MAC control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package pihh_pkg;

   localparam int FIELD_BITS  = 24;
   localparam int COORD_BITS  = 24;
   localparam int MARGIN_BITS = 20;
   localparam int DIFF_W      = COORD_BITS + 1;
   localparam int SUM_W       = COORD_BITS + 3;
   localparam int TOC_W       = COORD_BITS + 4;
   localparam int CROSS_W     = 2 * DIFF_W + 1;
   localparam int LO_BITS     = COORD_BITS + 2;
   localparam int HI_W        = CROSS_W - LO_BITS;
   localparam int MUL_W       = COORD_BITS + 4;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int ACC_W       = PROD_W + LO_BITS;
   localparam int CORNER_W    = 3 * COORD_BITS;

   localparam logic [0:0] OP_LOAD = 1'b0;
   localparam logic [0:0] OP_TEST = 1'b1;

   localparam logic [3:0] TRI_LAST = 4'd11;

   localparam logic [4:0] STEP_RD_C0       = 5'd0;
   localparam logic [4:0] STEP_RD_C1       = 5'd1;
   localparam logic [4:0] STEP_RD_C2       = 5'd2;
   localparam logic [4:0] STEP_DIFF        = 5'd3;
   localparam logic [4:0] STEP_CROSS_FIRST = 5'd4;
   localparam logic [4:0] STEP_NX          = 5'd6;
   localparam logic [4:0] STEP_NY          = 5'd8;
   localparam logic [4:0] STEP_CROSS_LAST  = 5'd9;
   localparam logic [4:0] STEP_NZ          = 5'd10;
   localparam logic [4:0] STEP_CHECK       = 5'd11;
   localparam logic [4:0] STEP_SIDE_FIRST  = 5'd12;
   localparam logic [4:0] STEP_SIDE_LAST   = 5'd17;
   localparam logic [4:0] STEP_DIST_FIRST  = 5'd18;
   localparam logic [4:0] STEP_DIST_LAST   = 5'd23;
   localparam logic [4:0] STEP_DECIDE      = 5'd24;
   localparam logic [4:0] STEP_SCAN_LAST   = 5'd8;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_TRI  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   typedef struct packed {
      logic en;
      logic clr;
      logic sub;
      logic shl;
   } mac_ctl_type;

   function automatic logic [8:0] tri_corners(input logic [3:0] t);
      logic [8:0] r;
      case (t)
         4'd0:    r = {3'd0, 3'd1, 3'd2};
         4'd1:    r = {3'd0, 3'd2, 3'd3};
         4'd2:    r = {3'd4, 3'd7, 3'd6};
         4'd3:    r = {3'd4, 3'd6, 3'd5};
         4'd4:    r = {3'd0, 3'd4, 3'd5};
         4'd5:    r = {3'd0, 3'd5, 3'd1};
         4'd6:    r = {3'd1, 3'd5, 3'd6};
         4'd7:    r = {3'd1, 3'd6, 3'd2};
         4'd8:    r = {3'd2, 3'd6, 3'd7};
         4'd9:    r = {3'd2, 3'd7, 3'd3};
         4'd10:   r = {3'd3, 3'd7, 3'd4};
         4'd11:   r = {3'd3, 3'd4, 3'd0};
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/point_in_hexahedron_half_space.sv
// ----------------------------------------------------------------------------
// point_in_hexahedron_half_space: point-in-cell test for a hexahedral cell
// Stores eight corners and tests query points against the twelve face
// triangles with one shared multiply-accumulate unit.
//
// Usage: drive req_* and raise start while busy is low. A load beat
// (operation 0) writes one corner, returns no result and leaves busy low.
// A test beat (operation 1) raises busy; the block first reads all eight
// corners for the sum and the coincidence check, then, unless all corners
// coincide, walks the triangles. A triangle whose normal is zero ends at its
// check step; the steps are bound by the single multiplier and the one-read
// corner memory. The walk stops at the first triangle the point is beyond.
// The result is on rsp_* for one cycle with rsp_valid high, and busy falls
// at that same edge. The receiver always takes the beat. csr_we writes the
// margin; the user must raise it only while the block is idle, which the
// block itself does not enforce. Reset clears the margin and the control
// state; corners are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_hexahedron_half_space
   import pihh_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         req_operation,
   input  wire logic [2:0]                   req_corner_index,
   input  wire logic signed [FIELD_BITS-1:0] req_coord_x,
   input  wire logic signed [FIELD_BITS-1:0] req_coord_y,
   input  wire logic signed [FIELD_BITS-1:0] req_coord_z,
   input  wire logic                         csr_we,
   input  wire logic [MARGIN_BITS-1:0]       csr_wdata,
   output logic                              rsp_valid,
   output logic                              rsp_inside_res,
   output logic                              rsp_degenerate_cell
);

   function automatic logic signed [COORD_BITS-1:0] to_coord(
      input logic [FIELD_BITS-1:0] v);
      logic signed [63:0] w;
      w = {{(64-FIELD_BITS){v[FIELD_BITS-1]}}, v};
      return w[COORD_BITS-1:0];
   endfunction

   function automatic logic signed [MUL_W-1:0] ext_diff(
      input logic signed [DIFF_W-1:0] v);
      return {{(MUL_W-DIFF_W){v[DIFF_W-1]}}, v};
   endfunction

   state_type                        state_ff, state_in;
   logic [4:0]                       step_ff, step_in;
   logic [3:0]                       tri_ff, tri_in;
   logic                             busy_ff, busy_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_inside_ff, rsp_inside_in;
   logic                             rsp_degen_ff, rsp_degen_in;
   logic [MARGIN_BITS-1:0]           margin_ff;

   logic [CORNER_W-1:0]              corner_mem [8];
   logic [CORNER_W-1:0]              rd_data_ff;
   logic [2:0]                       rd_addr;

   logic signed [COORD_BITS-1:0]     pt_ff [3];
   logic signed [COORD_BITS-1:0]     c0_ff [3];
   logic signed [COORD_BITS-1:0]     rd_c [3];
   logic signed [SUM_W-1:0]          sum_ff [3];
   logic                             degen_ff;
   logic                             degen_now;
   logic signed [DIFF_W-1:0]         e1_ff [3];
   logic signed [DIFF_W-1:0]         e2_ff [3];
   logic signed [DIFF_W-1:0]         top_ff [3];
   logic signed [TOC_W-1:0]          toc_ff [3];
   logic signed [CROSS_W-1:0]        n_ff [3];
   logic                             side_pos_ff;

   logic                             accept;
   logic [8:0]                       tc;
   logic [4:0]                       idx5;
   logic [2:0]                       idx;
   logic [1:0]                       comp;
   logic signed [MUL_W-1:0]          n_part;
   logic signed [MUL_W-1:0]          op_a, op_b;
   mac_ctl_type                      mac_ctl;
   logic signed [ACC_W-1:0]          acc;
   logic signed [ACC_W-1:0]          dist_val;
   logic signed [ACC_W-1:0]          margin_ext;
   logic                             beyond;
   logic                             n_zero;

   assign accept = start && !busy_ff;
   assign tc     = tri_corners(tri_ff);

   always_comb begin
      rd_c[0] = rd_data_ff[3*COORD_BITS-1:2*COORD_BITS];
      rd_c[1] = rd_data_ff[2*COORD_BITS-1:COORD_BITS];
      rd_c[2] = rd_data_ff[COORD_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (accept && (req_operation == OP_LOAD)) begin
         corner_mem[req_corner_index] <= {to_coord(req_coord_x), to_coord(req_coord_y),
                                          to_coord(req_coord_z)};
      end
      rd_data_ff <= corner_mem[rd_addr];
   end

   always_comb begin
      case (step_ff)
         STEP_RD_C0: rd_addr = tc[8:6];
         STEP_RD_C1: rd_addr = tc[5:3];
         STEP_RD_C2: rd_addr = tc[2:0];
         default:    rd_addr = tc[8:6];
      endcase
      if (state_ff == ST_SCAN) begin
         rd_addr = step_ff[2:0];
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      mac_ctl = '0;
      op_a    = '0;
      op_b    = '0;
      idx5    = '0;
      if ((step_ff >= STEP_SIDE_FIRST) && (step_ff <= STEP_SIDE_LAST)) begin
         idx5 = step_ff - STEP_SIDE_FIRST;
      end else if (step_ff >= STEP_DIST_FIRST) begin
         idx5 = step_ff - STEP_DIST_FIRST;
      end else begin
         idx5 = step_ff - STEP_CROSS_FIRST;
      end
      idx  = idx5[2:0];
      comp = idx[2:1];
      if (idx[0] == 1'b0) begin
         n_part = {{(MUL_W-HI_W){n_ff[comp][CROSS_W-1]}}, n_ff[comp][CROSS_W-1:LO_BITS]};
      end else begin
         n_part = {{(MUL_W-LO_BITS){1'b0}}, n_ff[comp][LO_BITS-1:0]};
      end
      if (state_ff == ST_TRI) begin
         if ((step_ff >= STEP_CROSS_FIRST) && (step_ff <= STEP_CROSS_LAST)) begin
            mac_ctl.en  = 1'b1;
            mac_ctl.clr = !idx[0];
            mac_ctl.sub = idx[0];
            case (idx)
               3'd0:    begin op_a = ext_diff(e1_ff[1]); op_b = ext_diff(e2_ff[2]); end
               3'd1:    begin op_a = ext_diff(e1_ff[2]); op_b = ext_diff(e2_ff[1]); end
               3'd2:    begin op_a = ext_diff(e1_ff[2]); op_b = ext_diff(e2_ff[0]); end
               3'd3:    begin op_a = ext_diff(e1_ff[0]); op_b = ext_diff(e2_ff[2]); end
               3'd4:    begin op_a = ext_diff(e1_ff[0]); op_b = ext_diff(e2_ff[1]); end
               3'd5:    begin op_a = ext_diff(e1_ff[1]); op_b = ext_diff(e2_ff[0]); end
               default: begin op_a = '0; op_b = '0; end
            endcase
         end else if ((step_ff >= STEP_SIDE_FIRST) && (step_ff <= STEP_DIST_LAST)) begin
            mac_ctl.en  = 1'b1;
            mac_ctl.clr = (step_ff == STEP_SIDE_FIRST) || (step_ff == STEP_DIST_FIRST);
            mac_ctl.shl = !idx[0];
            op_a        = n_part;
            if (step_ff <= STEP_SIDE_LAST) begin
               op_b = {{(MUL_W-TOC_W){toc_ff[comp][TOC_W-1]}}, toc_ff[comp]};
            end else begin
               op_b = ext_diff(top_ff[comp]);
            end
         end
      end
   end

   pihh_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (acc)
   );

   always_comb begin
      dist_val   = side_pos_ff ? -acc : acc;
      margin_ext = {{(ACC_W-MARGIN_BITS){1'b0}}, margin_ff};
      beyond     = dist_val > margin_ext;
      n_zero     = (n_ff[0] == '0) && (n_ff[1] == '0) && (n_ff[2] == '0);
      degen_now  = (step_ff == 5'd1) ||
                   (degen_ff && (rd_c[0] == c0_ff[0]) && (rd_c[1] == c0_ff[1]) &&
                    (rd_c[2] == c0_ff[2]));
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      tri_in        = tri_ff;
      busy_in       = busy_ff;
      rsp_valid_in  = 1'b0;
      rsp_inside_in = rsp_inside_ff;
      rsp_degen_in  = rsp_degen_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_operation == OP_TEST)) begin
               state_in = ST_SCAN;
               step_in  = '0;
               busy_in  = 1'b1;
            end
         end
         ST_SCAN: begin
            step_in = step_ff + 5'd1;
            if (step_ff == STEP_SCAN_LAST) begin
               step_in      = STEP_RD_C0;
               tri_in       = '0;
               rsp_degen_in = degen_now;
               if (degen_now) begin
                  state_in      = ST_DONE;
                  rsp_inside_in = (pt_ff[0] == c0_ff[0]) && (pt_ff[1] == c0_ff[1]) &&
                                  (pt_ff[2] == c0_ff[2]);
               end else begin
                  state_in = ST_TRI;
               end
            end
         end
         ST_TRI: begin
            step_in = step_ff + 5'd1;
            if (((step_ff == STEP_CHECK) && n_zero) ||
                ((step_ff == STEP_DECIDE) && !beyond)) begin
               step_in = STEP_RD_C0;
               tri_in  = tri_ff + 4'd1;
               if (tri_ff == TRI_LAST) begin
                  state_in      = ST_DONE;
                  rsp_inside_in = 1'b1;
               end
            end else if (step_ff == STEP_DECIDE) begin
               state_in      = ST_DONE;
               rsp_inside_in = 1'b0;
            end
         end
         ST_DONE: begin
            state_in     = ST_IDLE;
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         margin_ff    <= '0;
         step_ff      <= '0;
         tri_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         tri_ff       <= tri_in;
         if (csr_we) begin
            margin_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_inside_ff <= rsp_inside_in;
      rsp_degen_ff  <= rsp_degen_in;
      if (accept) begin
         pt_ff[0] <= to_coord(req_coord_x);
         pt_ff[1] <= to_coord(req_coord_y);
         pt_ff[2] <= to_coord(req_coord_z);
      end
      if ((state_ff == ST_SCAN) && (step_ff != 5'd0)) begin
         degen_ff <= degen_now;
         for (int k = 0; k < 3; k++) begin
            if (step_ff == 5'd1) begin
               c0_ff[k]  <= rd_c[k];
               sum_ff[k] <= SUM_W'(rd_c[k]);
            end else begin
               sum_ff[k] <= sum_ff[k] + SUM_W'(rd_c[k]);
            end
         end
      end
      if (state_ff == ST_TRI) begin
         for (int k = 0; k < 3; k++) begin
            case (step_ff)
               STEP_RD_C1: c0_ff[k] <= rd_c[k];
               STEP_RD_C2: e1_ff[k] <= DIFF_W'(rd_c[k]) - DIFF_W'(c0_ff[k]);
               STEP_DIFF: begin
                  e2_ff[k]  <= DIFF_W'(rd_c[k]) - DIFF_W'(c0_ff[k]);
                  top_ff[k] <= DIFF_W'(pt_ff[k]) - DIFF_W'(c0_ff[k]);
                  toc_ff[k] <= TOC_W'(sum_ff[k]) - (TOC_W'(c0_ff[k]) <<< 3);
               end
               default: begin
               end
            endcase
         end
         case (step_ff)
            STEP_NX:         n_ff[0] <= acc[CROSS_W-1:0];
            STEP_NY:         n_ff[1] <= acc[CROSS_W-1:0];
            STEP_NZ:         n_ff[2] <= acc[CROSS_W-1:0];
            STEP_DIST_FIRST: side_pos_ff <= !acc[ACC_W-1] && (acc != '0);
            default: begin
            end
         endcase
      end
   end

   assign busy                = busy_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_inside_res      = rsp_inside_ff;
   assign rsp_degenerate_cell = rsp_degen_ff;

endmodule

`default_nettype wire

FILE: rtl/pihh_mac.sv
// ----------------------------------------------------------------------------
// pihh_mac: shared multiply-accumulate unit
// One signed multiply per cycle while ctl.en is high, optionally shifted
// up, added to or subtracted from a wide accumulator, or loaded into it.
// ----------------------------------------------------------------------------
`default_nettype none

module pihh_mac
   import pihh_pkg::*;
(
   input  wire logic                     clock,
   input  wire mac_ctl_type              ctl,
   input  wire logic signed [MUL_W-1:0]  op_a,
   input  wire logic signed [MUL_W-1:0]  op_b,
   output logic signed [ACC_W-1:0]       acc
);

   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  term;
   logic signed [ACC_W-1:0]  base;

   always_comb begin
      prod   = op_a * op_b;
      term   = ACC_W'(prod);
      if (ctl.shl) begin
         term = term <<< LO_BITS;
      end
      base   = ctl.clr ? '0 : acc_ff;
      acc_in = ctl.sub ? base - term : base + term;
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for point_in_hexahedron_half_space
// Loads hexahedral cells corner by corner and queries points against them.
// A directed table comes first, then random cells of many sizes, degenerate
// corners and random margins. Every test beat is predicted with wide exact
// arithmetic and each result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import pihh_pkg::*;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic [0:0]        op;
      logic [2:0]        idx;
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] z;
      bit                known;
      bit                want_inside;
      bit                want_degen;
   } row_type;

   typedef struct {
      bit in_cell;
      bit degen;
   } verdict_type;

   localparam longint LIMIT = 3000000;
   localparam int TAB_LEN = 22;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_operation = 1'b0;
   logic [2:0] req_corner_index = '0;
   logic signed [FIELD_BITS-1:0] req_coord_x = '0;
   logic signed [FIELD_BITS-1:0] req_coord_y = '0;
   logic signed [FIELD_BITS-1:0] req_coord_z = '0;
   logic csr_we = 1'b0;
   logic [MARGIN_BITS-1:0] csr_wdata = '0;
   logic rsp_valid;
   logic rsp_inside_res;
   logic rsp_degenerate_cell;

   logic signed [23:0] cell_x [8];
   logic signed [23:0] cell_y [8];
   logic signed [23:0] cell_z [8];
   logic [19:0] margin_reg;
   verdict_type pending_verdicts [$];
   int failures = 0;
   longint cycles = 0;
   row_type dir_tab [TAB_LEN];

   int tri_tab [12][3] = '{
      '{0, 1, 2}, '{0, 2, 3}, '{4, 7, 6}, '{4, 6, 5}, '{0, 4, 5}, '{0, 5, 1},
      '{1, 5, 6}, '{1, 6, 2}, '{2, 6, 7}, '{2, 7, 3}, '{3, 7, 4}, '{3, 4, 0}
   };

   point_in_hexahedron_half_space u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_corner_index(req_corner_index),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .req_coord_z(req_coord_z), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_inside_res(rsp_inside_res),
      .rsp_degenerate_cell(rsp_degenerate_cell)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      verdict_type w;
      if (!reset && rsp_valid) begin
         if (pending_verdicts.size() == 0) begin
            $error("unexpected result beat");
            failures++;
         end else begin
            w = pending_verdicts.pop_front();
            if (rsp_inside_res !== w.in_cell) begin
               $error("inside_res expected %0d got %0d", w.in_cell, rsp_inside_res);
               failures++;
            end
            if (rsp_degenerate_cell !== w.degen) begin
               $error("degenerate_cell expected %0d got %0d", w.degen,
                      rsp_degenerate_cell);
               failures++;
            end
         end
      end
   end

   function automatic bit beyond_plane(int a, int b, int c, wide_type px, wide_type py,
                                       wide_type pz, wide_type sx, wide_type sy,
                                       wide_type sz);
      wide_type ax, ay, az, e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz, side, dist_v, m;
      ax = wide_type'(cell_x[a]);
      ay = wide_type'(cell_y[a]);
      az = wide_type'(cell_z[a]);
      e1x = wide_type'(cell_x[b]) - ax;
      e1y = wide_type'(cell_y[b]) - ay;
      e1z = wide_type'(cell_z[b]) - az;
      e2x = wide_type'(cell_x[c]) - ax;
      e2y = wide_type'(cell_y[c]) - ay;
      e2z = wide_type'(cell_z[c]) - az;
      nx = e1y * e2z - e1z * e2y;
      ny = e1z * e2x - e1x * e2z;
      nz = e1x * e2y - e1y * e2x;
      if (nx == 0 && ny == 0 && nz == 0) return 1'b0;
      side = nx * (sx - 8 * ax) + ny * (sy - 8 * ay) + nz * (sz - 8 * az);
      dist_v = nx * (px - ax) + ny * (py - ay) + nz * (pz - az);
      if (side > 0) dist_v = -dist_v;
      m = {108'd0, margin_reg};
      return dist_v > m;
   endfunction

   function automatic verdict_type judge_point(logic signed [23:0] x,
                                               logic signed [23:0] y,
                                               logic signed [23:0] z);
      verdict_type v;
      wide_type sx, sy, sz;
      sx = 0;
      sy = 0;
      sz = 0;
      v.degen = 1'b1;
      v.in_cell = 1'b1;
      for (int i = 0; i < 8; i++) begin
         sx += wide_type'(cell_x[i]);
         sy += wide_type'(cell_y[i]);
         sz += wide_type'(cell_z[i]);
         if (cell_x[i] != cell_x[0] || cell_y[i] != cell_y[0] || cell_z[i] != cell_z[0])
            v.degen = 1'b0;
      end
      if (v.degen) begin
         v.in_cell = (x == cell_x[0] && y == cell_y[0] && z == cell_z[0]);
      end else begin
         for (int t = 0; t < 12; t++)
            if (beyond_plane(tri_tab[t][0], tri_tab[t][1], tri_tab[t][2],
                             wide_type'(x), wide_type'(y), wide_type'(z), sx, sy, sz))
               v.in_cell = 1'b0;
      end
      return v;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [23:0] clamp24(longint v);
      if (v > 8388607) return 24'sd8388607;
      if (v < -8388608) return -24'sd8388608;
      return v[23:0];
   endfunction

   task automatic send_beat(logic [0:0] op, logic [2:0] idx, logic signed [23:0] x,
                            logic signed [23:0] y, logic signed [23:0] z,
                            bit known, bit want_inside, bit want_degen, int gap);
      verdict_type v;
      req_operation <= op;
      req_corner_index <= idx;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      if (op == OP_LOAD) begin
         cell_x[idx] = x;
         cell_y[idx] = y;
         cell_z[idx] = z;
      end else begin
         v = judge_point(x, y, z);
         if (known && (v.in_cell != want_inside || v.degen != want_degen)) begin
            $error("table row disagrees with prediction");
            failures++;
         end
         pending_verdicts.push_back(v);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic set_margin(logic [19:0] value);
      start <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      margin_reg = value;
      @(posedge clock);
   endtask

   task automatic random_cell(longint s, bit collapse);
      longint cx, cy, cz, room, j;
      logic signed [23:0] px, py, pz;
      int n_tests, k, r;
      room = 8388607 - 2 * s;
      cx = $urandom_range(0, 2 * room) - room;
      cy = $urandom_range(0, 2 * room) - room;
      cz = $urandom_range(0, 2 * room) - room;
      j = (s / 4) + 1;
      for (int i = 0; i < 8; i++) begin
         px = clamp24(cx + ((i == 1 || i == 2 || i == 5 || i == 6) ? s : -s)
                      + $urandom_range(0, 2 * j) - j);
         py = clamp24(cy + ((i == 2 || i == 3 || i == 6 || i == 7) ? s : -s)
                      + $urandom_range(0, 2 * j) - j);
         pz = clamp24(cz + (i < 4 ? s : -s) + $urandom_range(0, 2 * j) - j);
         if (collapse && $urandom_range(0, 1)) begin
            px = cx[23:0];
            py = cy[23:0];
            pz = cz[23:0];
         end
         send_beat(OP_LOAD, 3'(i), px, py, pz, 0, 0, 0, gap_len());
      end
      n_tests = $urandom_range(3, 9);
      for (int t = 0; t < n_tests; t++) begin
         r = $urandom_range(0, 9);
         if (r < 6) begin
            px = clamp24(cx + $urandom_range(0, 4 * s + 4) - 2 * s - 2);
            py = clamp24(cy + $urandom_range(0, 4 * s + 4) - 2 * s - 2);
            pz = clamp24(cz + $urandom_range(0, 4 * s + 4) - 2 * s - 2);
         end else if (r < 8) begin
            k = $urandom_range(0, 7);
            px = cell_x[k];
            py = cell_y[k];
            pz = cell_z[k];
         end else begin
            px = 24'($urandom);
            py = 24'($urandom);
            pz = 24'($urandom);
         end
         send_beat(OP_TEST, 3'($urandom), px, py, pz, 0, 0, 0, gap_len());
      end
   endtask

   initial begin
      longint s;
      int r;
      dir_tab = '{
         '{OP_LOAD, 3'd0, -100, -100, 100, 0, 0, 0},
         '{OP_LOAD, 3'd1, 100, -100, 100, 0, 0, 0},
         '{OP_LOAD, 3'd2, 100, 100, 100, 0, 0, 0},
         '{OP_LOAD, 3'd3, -100, 100, 100, 0, 0, 0},
         '{OP_LOAD, 3'd4, -100, -100, -100, 0, 0, 0},
         '{OP_LOAD, 3'd5, 100, -100, -100, 0, 0, 0},
         '{OP_LOAD, 3'd6, 100, 100, -100, 0, 0, 0},
         '{OP_LOAD, 3'd7, -100, 100, -100, 0, 0, 0},
         '{OP_TEST, 3'd7, 0, 0, 0, 1, 1, 0},
         '{OP_TEST, 3'd0, 5000000, 0, 0, 1, 0, 0},
         '{OP_TEST, 3'd5, 100, 100, 100, 1, 1, 0},
         '{OP_TEST, 3'd2, -8388608, 8388607, -8388608, 1, 0, 0},
         '{OP_LOAD, 3'd0, -8388608, 8388607, -8388608, 0, 0, 0},
         '{OP_LOAD, 3'd1, -8388608, 8388607, -8388608, 0, 0, 0},
         '{OP_LOAD, 3'd2, -8388608, 8388607, -8388608, 0, 0, 0},
         '{OP_LOAD, 3'd3, -8388608, 8388607, -8388608, 0, 0, 0},
         '{OP_LOAD, 3'd4, -8388608, 8388607, -8388608, 0, 0, 0},
         '{OP_LOAD, 3'd5, -8388608, 8388607, -8388608, 0, 0, 0},
         '{OP_LOAD, 3'd6, -8388608, 8388607, -8388608, 0, 0, 0},
         '{OP_LOAD, 3'd7, -8388608, 8388607, -8388608, 0, 0, 0},
         '{OP_TEST, 3'd7, -8388608, 8388607, -8388608, 1, 1, 1},
         '{OP_TEST, 3'd0, 8388607, -8388608, 8388607, 1, 0, 1}
      };
      margin_reg = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < TAB_LEN; i++)
         send_beat(dir_tab[i].op, dir_tab[i].idx, dir_tab[i].x, dir_tab[i].y,
                   dir_tab[i].z, dir_tab[i].known, dir_tab[i].want_inside,
                   dir_tab[i].want_degen, gap_len());
      set_margin(20'hFFFFF);
      random_cell(3, 0);
      random_cell(1000, 0);
      set_margin(20'd0);
      for (int c = 0; c < 100; c++) begin
         if (c % 12 == 11) begin
            r = $urandom_range(0, 3);
            set_margin(r == 0 ? 20'd0 : r == 1 ? 20'hFFFFF :
                       r == 2 ? 20'($urandom_range(1, 64)) : 20'($urandom));
         end
         r = $urandom_range(0, 19);
         if (r < 12) s = $urandom_range(1, 40);
         else if (r < 17) s = $urandom_range(41, 20000);
         else s = $urandom_range(20001, 4000000);
         random_cell(s, $urandom_range(0, 9) == 0);
      end
      start <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire

FILE: point_in_hexahedron_half_space.f
rtl/pihh_pkg.sv
rtl/pihh_mac.sv
rtl/point_in_hexahedron_half_space.sv
tb/tb.sv
